@@ hw/rtl/krs_pkg.sv @@
// shared types and codes for the keyed record set
package krs_pkg;

    localparam int KEY_W    = 44;
    localparam int YEAR_W   = 12;
    localparam int GENDER_W = 8;
    localparam int TOTAL_W  = 6;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [YEAR_W-1:0]   year;
        logic [GENDER_W-1:0] gender;
    } record_t;

    typedef logic [1:0] opcode_t;
    typedef logic [2:0] status_t;

    localparam opcode_t OP_ADD    = 2'd0;
    localparam opcode_t OP_REMOVE = 2'd1;

    localparam status_t ST_ADDED     = 3'd0;
    localparam status_t ST_DUPLICATE = 3'd1;
    localparam status_t ST_FULL      = 3'd2;
    localparam status_t ST_REMOVED   = 3'd3;
    localparam status_t ST_NOTFOUND  = 3'd4;
    localparam status_t ST_COUNT     = 3'd5;

endpackage

@@ hw/rtl/krs_seq.sv @@
// sequencer: key search, append and compaction over the record memory
module krs_seq
    import krs_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int CW       = 6,
    parameter int AW       = 5
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          opcode,
    input  logic [KEY_W-1:0]    key,
    input  logic [YEAR_W-1:0]   birth_year,
    input  logic [GENDER_W-1:0] gender,
    output logic                busy,
    output logic                mem_re,
    output logic [AW-1:0]       mem_raddr,
    input  record_t             mem_rdata,
    output logic                mem_we,
    output logic [AW-1:0]       mem_waddr,
    output record_t             mem_wdata,
    output logic                done,
    output logic [2:0]          status,
    output logic [TOTAL_W-1:0]  entry_total
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    logic [1:0]         state_reg, state_next;
    logic               is_add_reg, is_add_next;
    record_t            rec_reg, rec_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic [CW-1:0]      wr_idx_reg, wr_idx_next;
    logic               done_reg, done_next;
    status_t            status_reg, status_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    logic          issue;
    logic          match;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] cnt_dec;

    // count as seen on the 6-bit result field
    function automatic logic [TOTAL_W-1:0] to_total(input logic [CW-1:0] c);
        logic [CW+TOTAL_W-1:0] wide;
        wide = {{TOTAL_W{1'b0}}, c};
        return wide[TOTAL_W-1:0];
    endfunction

    assign issue   = (idx_reg < cnt_reg);
    assign match   = pend_reg && (mem_rdata.key == rec_reg.key);
    assign cnt_inc = cnt_reg + 1'b1;
    assign cnt_dec = cnt_reg - 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        is_add_next = is_add_reg;
        rec_next    = rec_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        pend_next   = pend_reg;
        wr_idx_next = wr_idx_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        total_next  = total_reg;
        mem_re      = 1'b0;
        mem_raddr   = idx_reg[AW-1:0];
        mem_we      = 1'b0;
        mem_waddr   = wr_idx_reg[AW-1:0];
        mem_wdata   = mem_rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    is_add_next = (opcode == OP_ADD);
                    rec_next    = '{key: key, year: birth_year, gender: gender};
                    if (opcode == OP_ADD || opcode == OP_REMOVE)
                    begin
                        state_next = S_SCAN;
                        idx_next   = '0;
                        pend_next  = 1'b0;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = ST_COUNT;
                        total_next  = to_total(cnt_reg);
                    end
                end
            end

            S_SCAN:
            begin
                if (match && is_add_reg)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = ST_DUPLICATE;
                    total_next  = to_total(cnt_reg);
                end
                else if (match)
                begin
                    // issue the read of the entry after the hit, if one remains
                    state_next  = S_SHIFT;
                    wr_idx_next = idx_reg - 1'b1;
                    mem_re      = issue;
                    pend_next   = issue;
                    if (issue)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (idx_reg == cnt_reg)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    if (!is_add_reg)
                    begin
                        status_next = ST_NOTFOUND;
                        total_next  = to_total(cnt_reg);
                    end
                    else if (cnt_reg == CAP_CNT)
                    begin
                        status_next = ST_FULL;
                        total_next  = to_total(cnt_reg);
                    end
                    else
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = cnt_reg[AW-1:0];
                        mem_wdata   = rec_reg;
                        cnt_next    = cnt_inc;
                        status_next = ST_ADDED;
                        total_next  = to_total(cnt_inc);
                    end
                end
                else
                begin
                    mem_re    = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
            end

            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    // move the arriving entry down one place
                    mem_we      = 1'b1;
                    wr_idx_next = wr_idx_reg + 1'b1;
                    mem_re      = issue;
                    pend_next   = issue;
                    if (issue)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    cnt_next    = cnt_dec;
                    status_next = ST_REMOVED;
                    total_next  = to_total(cnt_dec);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_add_reg <= is_add_next;
        rec_reg    <= rec_next;
        idx_reg    <= idx_next;
        pend_reg   <= pend_next;
        wr_idx_reg <= wr_idx_next;
        status_reg <= status_next;
        total_reg  <= total_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_total = total_reg;

endmodule

@@ hw/rtl/keyed_record_set.sv @@
// top level: record memory and search/compaction sequencer
//
//  channel   direction  handshake         fields
//  command   in         start / busy      opcode, key, birth_year, gender
//  result    out        done (strobe)     status, entry_total
//
// a query answers in the cycle after start; an add or a remove scans the
// stored entries, with one memory read per entry scanned.
// the removal shift streams read and write-back through the one memory.
// rst_n clears the count and the sequencer; the memory holds no reset.
// busy is high after an accepted add or remove start until done is shown.
// done lasts one cycle and cannot be held off by the receiver.
module keyed_record_set
    import krs_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          opcode,
    input  logic [KEY_W-1:0]    key,
    input  logic [YEAR_W-1:0]   birth_year,
    input  logic [GENDER_W-1:0] gender,
    output logic                done,
    output logic [2:0]          status,
    output logic [TOTAL_W-1:0]  entry_total
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    record_t       mem_rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    record_t       mem_wdata;

    record_t       rec_mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rec_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= rec_mem[mem_raddr];
        end
    end

    krs_seq #(
        .CAPACITY (CAPACITY),
        .CW       (CW),
        .AW       (AW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .opcode      (opcode),
        .key         (key),
        .birth_year  (birth_year),
        .gender      (gender),
        .busy        (busy),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata_reg),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .done        (done),
        .status      (status),
        .entry_total (entry_total)
    );

endmodule
